// File: src/msig_pkg.sv
// shared types, register codes and constants of the multispark ignition pulse generator
package msig_pkg;

  localparam int NUM_CHANNELS_DEF = 3;
  localparam int TIME_BITS_DEF    = 16;
  localparam int NUM_IO           = 3;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_INDEX_W      = 3;
  localparam int COUNT_W          = 3;
  localparam int DWELL_W          = 13;

  localparam logic [COUNT_W-1:0]    CYCLES_MAX  = 3'd5;
  localparam logic [DWELL_W-1:0]    DWELL_MAX   = 13'd5000;

  localparam logic                  RST_SECOND_COIL_ENABLE = 1'b0;
  localparam logic [CFG_DATA_W-1:0] RST_PHASING_TIME       = 16'd200;
  localparam logic [COUNT_W-1:0]    RST_PRIMARY_CYCLES     = 3'd3;
  localparam logic [COUNT_W-1:0]    RST_SECONDARY_CYCLES   = 3'd3;
  localparam logic [CFG_DATA_W-1:0] RST_BURST_INTERVAL     = 16'd500;
  localparam logic [DWELL_W-1:0]    RST_BURST_DWELL        = 13'd1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SECOND_COIL_ENABLE = 3'd0,
    REG_PHASING_TIME       = 3'd1,
    REG_PRIMARY_CYCLES     = 3'd2,
    REG_SECONDARY_CYCLES   = 3'd3,
    REG_BURST_INTERVAL     = 3'd4,
    REG_BURST_DWELL        = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic                  second_coil_enable;
    logic [CFG_DATA_W-1:0] phasing_time;
    logic [COUNT_W-1:0]    primary_cycles;
    logic [COUNT_W-1:0]    secondary_cycles;
    logic [CFG_DATA_W-1:0] burst_interval;
    logic [DWELL_W-1:0]    burst_dwell;
  } cfg_t;

endpackage

// File: src/msig_lane.sv
// one channel lane: main coil follower and burst, phased coil delay and burst
module msig_lane import msig_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic lvl,
  input  cfg_t cfg,
  output logic main_coil_next,
  output logic phase_coil_next
);

  localparam int CW = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic               in_burst;
    logic               out;
    logic [COUNT_W-1:0] count;
    logic [CW-1:0]      el;
  } burst_t;

  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    sat_inc = (v == TIME_MAX) ? v : v + 1'b1;
  endfunction

  // extra-spark sequencer, shared form for both coils
  function automatic burst_t burst_step(input burst_t s, input logic [COUNT_W-1:0] cycles,
                                        input logic [CW-1:0] interval,
                                        input logic [CW-1:0] dwell);
    burst_t r;
    r = s;
    if (s.in_burst) begin
      if (({1'b0, s.count} + 4'd2) <= {1'b0, cycles}) begin
        if (!s.out) begin
          if (s.el >= interval) begin
            r.out = 1'b1;
            r.el  = '0;
          end
        end else if (s.el >= dwell) begin
          r.out   = 1'b0;
          r.el    = '0;
          r.count = s.count + 1'b1;
        end
      end else begin
        r.count    = '0;
        r.in_burst = 1'b0;
      end
    end
    burst_step = r;
  endfunction

  logic                 chan_armed, chan_armed_next;
  logic                 last_level;
  logic                 main_seen_high, main_seen_high_next;
  logic                 main_in_burst, main_out;
  logic [TIME_BITS-1:0] main_elapsed;
  logic [COUNT_W-1:0]   main_spark_count;
  logic                 phase_seen_high, phase_seen_high_next;
  logic                 phase_after_fall, phase_after_fall_next;
  logic                 phase_in_burst, phase_out;
  logic [TIME_BITS-1:0] phase_elapsed;
  logic [COUNT_W-1:0]   phase_spark_count;

  burst_t        mb, pb;
  logic [CW-1:0] phasing, interval, dwell;

  assign phasing  = CW'(cfg.phasing_time);
  assign interval = CW'(cfg.burst_interval);
  assign dwell    = CW'(cfg.burst_dwell);

  always_comb begin
    chan_armed_next       = chan_armed;
    main_seen_high_next   = main_seen_high;
    phase_seen_high_next  = phase_seen_high;
    phase_after_fall_next = phase_after_fall;
    mb.in_burst = main_in_burst;
    mb.out      = main_out;
    mb.count    = main_spark_count;
    mb.el       = CW'(sat_inc(main_elapsed));
    pb.in_burst = phase_in_burst;
    pb.out      = phase_out;
    pb.count    = phase_spark_count;
    pb.el       = CW'(sat_inc(phase_elapsed));

    if (lvl && !last_level) begin
      chan_armed_next = 1'b1;
      pb.el           = '0;
    end

    if (chan_armed_next) begin
      // main coil
      if (lvl) begin
        mb.out              = 1'b1;
        main_seen_high_next = 1'b1;
      end else begin
        if (main_seen_high) begin
          main_seen_high_next = 1'b0;
          mb.out              = 1'b0;
          mb.el               = '0;
          mb.in_burst         = 1'b1;
        end
        mb = burst_step(mb, cfg.primary_cycles, interval, dwell);
      end

      // phased coil, frozen while disabled
      if (cfg.second_coil_enable) begin
        if (lvl) begin
          if (pb.el >= phasing) begin
            pb.out               = 1'b1;
            phase_seen_high_next = 1'b1;
          end else begin
            pb.out = 1'b0;
          end
        end else begin
          if (phase_seen_high) begin
            phase_seen_high_next  = 1'b0;
            phase_after_fall_next = 1'b1;
            pb.el                 = '0;
          end
          if (phase_after_fall_next) begin
            if (pb.el >= phasing) begin
              pb.out                = 1'b0;
              pb.el                 = '0;
              phase_after_fall_next = 1'b0;
              pb.in_burst           = 1'b1;
            end else begin
              pb.out = 1'b1;
            end
          end
          if (!phase_after_fall_next) begin
            pb = burst_step(pb, cfg.secondary_cycles, interval, dwell);
          end
        end
      end
    end
  end

  assign main_coil_next  = mb.out;
  assign phase_coil_next = pb.out;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_armed        <= 1'b0;
      last_level        <= 1'b0;
      main_seen_high    <= 1'b0;
      main_in_burst     <= 1'b0;
      main_out          <= 1'b0;
      main_elapsed      <= '0;
      main_spark_count  <= '0;
      phase_seen_high   <= 1'b0;
      phase_after_fall  <= 1'b0;
      phase_in_burst    <= 1'b0;
      phase_out         <= 1'b0;
      phase_elapsed     <= '0;
      phase_spark_count <= '0;
    end else if (en) begin
      chan_armed        <= chan_armed_next;
      last_level        <= lvl;
      main_seen_high    <= main_seen_high_next;
      main_in_burst     <= mb.in_burst;
      main_out          <= mb.out;
      main_elapsed      <= mb.el[TIME_BITS-1:0];
      main_spark_count  <= mb.count;
      phase_seen_high   <= phase_seen_high_next;
      phase_after_fall  <= phase_after_fall_next;
      phase_in_burst    <= pb.in_burst;
      phase_out         <= pb.out;
      phase_elapsed     <= pb.el[TIME_BITS-1:0];
      phase_spark_count <= pb.count;
    end
  end

endmodule

// File: src/multispark_ignition_pulse_generator.sv
// top level: configuration registers, channel lanes and the output merge with skid stage
//
// Each input transfer is one microsecond tick carrying the sampled trigger
// level of three channels; each output transfer carries the six coil drives
// after that tick. The block takes one tick per clock while the skid register is
// empty and answers each tick with exactly one registered result. Every channel
// has its own lane (saturating elapsed counters, edge detect, main and phased burst
// sequencers) that updates its state on the input transfer; the lane results
// are merged into one output word held in an output register backed by a
// one-entry skid register, so input ready depends only on the skid register
// and not combinationally on output ready. The main coil follows the trigger
// while high and then fires primary_cycles-1 rest/dwell sparks; when
// second_coil_enable is set the phased coil follows the trigger delayed by
// phasing_time on both edges and then fires secondary_cycles-1 sparks.
// Configuration is written through cfg_we/cfg_index/cfg_data with no wait; the
// low 3 bits of cycle counts clamp to 5, the low 13 bits of dwell to 5000, unknown
// indexes are dropped. Configuration should only change while no tick is in flight.
module multispark_ignition_pulse_generator import msig_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // tick input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   trig_level_a,
  input  logic                   trig_level_b,
  input  logic                   trig_level_c,
  // coil result output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   main_coil_a,
  output logic                   phased_coil_a,
  output logic                   main_coil_b,
  output logic                   phased_coil_b,
  output logic                   main_coil_c,
  output logic                   phased_coil_c
);

  cfg_t cfg_q;

  // configuration registers with clamping
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.second_coil_enable <= RST_SECOND_COIL_ENABLE;
      cfg_q.phasing_time       <= RST_PHASING_TIME;
      cfg_q.primary_cycles     <= RST_PRIMARY_CYCLES;
      cfg_q.secondary_cycles   <= RST_SECONDARY_CYCLES;
      cfg_q.burst_interval     <= RST_BURST_INTERVAL;
      cfg_q.burst_dwell        <= RST_BURST_DWELL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SECOND_COIL_ENABLE: cfg_q.second_coil_enable <= cfg_data[0];
        REG_PHASING_TIME:       cfg_q.phasing_time       <= cfg_data;
        REG_PRIMARY_CYCLES:
          cfg_q.primary_cycles <= (cfg_data[COUNT_W-1:0] > CYCLES_MAX) ?
                                  CYCLES_MAX : cfg_data[COUNT_W-1:0];
        REG_SECONDARY_CYCLES:
          cfg_q.secondary_cycles <= (cfg_data[COUNT_W-1:0] > CYCLES_MAX) ?
                                    CYCLES_MAX : cfg_data[COUNT_W-1:0];
        REG_BURST_INTERVAL:     cfg_q.burst_interval     <= cfg_data;
        REG_BURST_DWELL:
          cfg_q.burst_dwell <= (cfg_data[DWELL_W-1:0] > DWELL_MAX) ?
                               DWELL_MAX : cfg_data[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // input transfer and lane fan-out
  logic                    accept;
  logic [NUM_IO-1:0]       trig_io;
  logic [NUM_CHANNELS-1:0] lane_lvl;
  logic [NUM_CHANNELS-1:0] lane_main, lane_phase;

  assign accept  = in_valid && in_ready;
  assign trig_io = {trig_level_c, trig_level_b, trig_level_a};

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    // channels without a trigger pin see a low level
    if (c < NUM_IO) begin : g_pin
      assign lane_lvl[c] = trig_io[c];
    end else begin : g_nopin
      assign lane_lvl[c] = 1'b0;
    end

    msig_lane #(
      .TIME_BITS(TIME_BITS)
    ) u_lane (
      .clk            (clk),
      .rst            (rst),
      .en             (accept),
      .lvl            (lane_lvl[c]),
      .cfg            (cfg_q),
      .main_coil_next (lane_main[c]),
      .phase_coil_next(lane_phase[c])
    );
  end

  // merge lane results into the result word, main/phased interleaved per channel
  logic [2*NUM_IO-1:0] result;

  for (genvar c = 0; c < NUM_IO; c++) begin : g_merge
    if (c < NUM_CHANNELS) begin : g_used
      assign result[2*c]   = lane_main[c];
      assign result[2*c+1] = lane_phase[c];
    end else begin : g_unused
      assign result[2*c]   = 1'b0;
      assign result[2*c+1] = 1'b0;
    end
  end

  // output register plus skid entry
  logic                out_full;
  logic [2*NUM_IO-1:0] out_data;
  logic                skid_valid;
  logic [2*NUM_IO-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_full || out_ready) begin
      // output slot free after this edge: skid entry drains first
      out_full   <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || out_ready) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign out_valid     = out_full;
  assign main_coil_a   = out_data[0];
  assign phased_coil_a = out_data[1];
  assign main_coil_b   = out_data[2];
  assign phased_coil_b = out_data[3];
  assign main_coil_c   = out_data[4];
  assign phased_coil_c = out_data[5];

  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_full)
    else $error("skid entry valid with empty output register");

  // a transfer into a stalled full output lands in the skid entry
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_full && !out_ready) |=> skid_valid)
    else $error("transfer lost while output stalled");

  // every transfer leaves a result waiting
  a_accept_visible: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_full)
    else $error("transfer produced no result");

  // clamped registers stay in range
  a_cfg_range: assert property (@(posedge clk) disable iff (rst)
    (cfg_q.primary_cycles <= CYCLES_MAX) && (cfg_q.secondary_cycles <= CYCLES_MAX) &&
    (cfg_q.burst_dwell <= DWELL_MAX))
    else $error("configuration register out of range");

endmodule

// File: tb/multispark_ignition_pulse_generator_test.sv
// self-checking regression bench for the multispark ignition pulse generator
module multispark_ignition_pulse_generator_test import msig_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // length of the forced output hold-off in the backpressure test
  localparam int HOLD_CYCLES = 200;
  localparam logic [TIME_BITS_DEF-1:0] ELAPSED_MAX = '1;
  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic trig_level_a;
  logic trig_level_b;
  logic trig_level_c;
  logic out_valid;
  logic out_ready = 1'b0;
  logic main_coil_a;
  logic phased_coil_a;
  logic main_coil_b;
  logic phased_coil_b;
  logic main_coil_c;
  logic phased_coil_c;

  multispark_ignition_pulse_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .trig_level_a  (trig_level_a),
    .trig_level_b  (trig_level_b),
    .trig_level_c  (trig_level_c),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .main_coil_a   (main_coil_a),
    .phased_coil_a (phased_coil_a),
    .main_coil_b   (main_coil_b),
    .phased_coil_b (phased_coil_b),
    .main_coil_c   (main_coil_c),
    .phased_coil_c (phased_coil_c)
  );

  // per-channel image of the block's timers, sequencers and coil drives
  typedef struct packed {
    logic                     armed;
    logic                     last_lvl;
    logic                     main_seen;
    logic                     main_burst;
    logic                     main_on;
    logic [TIME_BITS_DEF-1:0] main_time;
    logic [COUNT_W-1:0]       main_sparks;
    logic                     phase_seen;
    logic                     phase_falling;
    logic                     phase_burst;
    logic                     phase_on;
    logic [TIME_BITS_DEF-1:0] phase_time;
    logic [COUNT_W-1:0]       phase_sparks;
  } lane_t;

  lane_t lane [NUM_IO];
  cfg_t coil_cfg;

  // coil words still owed by the block, bit 2c is main coil c, bit 2c+1 phased coil c
  logic [2*NUM_IO-1:0] coil_q [$];
  logic [2*NUM_IO-1:0] coils_seen;
  logic [2*NUM_IO-1:0] coils_due;
  string coil_names [2*NUM_IO] = '{"main_coil_a", "phased_coil_a", "main_coil_b",
                                   "phased_coil_b", "main_coil_c", "phased_coil_c"};
  int mismatches = 0;

  // idle percentages of the two sides, changed per phase
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  // random trigger waveform state, one run length per channel
  logic [NUM_IO-1:0] wave_lvl = '0;
  int wave_left [NUM_IO] = '{default: 0};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // one extra-spark step: rest, then dwell, until the spark budget is spent
  task automatic advance_spark(inout logic burst, inout logic on,
                               inout logic [TIME_BITS_DEF-1:0] elapsed,
                               inout logic [COUNT_W-1:0] sparks,
                               input logic [COUNT_W-1:0] total);
    if (burst) begin
      if (int'(sparks) + 2 <= int'(total)) begin
        if (!on) begin
          if (elapsed >= coil_cfg.burst_interval) begin
            on = 1'b1;
            elapsed = '0;
          end
        end else if (elapsed >= coil_cfg.burst_dwell) begin
          on = 1'b0;
          elapsed = '0;
          sparks = sparks + 1'b1;
        end
      end else begin
        sparks = '0;
        burst = 1'b0;
      end
    end
  endtask

  // advance every channel by one microsecond tick and queue the coil word it gives
  task automatic predict_tick(input logic [NUM_IO-1:0] lvl);
    logic [2*NUM_IO-1:0] coils;
    for (int c = 0; c < NUM_IO; c++) begin
      lane[c].main_time = (lane[c].main_time == ELAPSED_MAX) ? ELAPSED_MAX
                                                             : lane[c].main_time + 1'b1;
      lane[c].phase_time = (lane[c].phase_time == ELAPSED_MAX) ? ELAPSED_MAX
                                                               : lane[c].phase_time + 1'b1;
      // a rise arms the channel for good and restarts the phasing timer
      if (lvl[c] && !lane[c].last_lvl) begin
        lane[c].armed = 1'b1;
        lane[c].phase_time = '0;
      end
      lane[c].last_lvl = lvl[c];
      if (lane[c].armed) begin
        // main coil follows the trigger, then runs its burst after the fall
        if (lvl[c]) begin
          lane[c].main_on = 1'b1;
          lane[c].main_seen = 1'b1;
        end else begin
          if (lane[c].main_seen) begin
            lane[c].main_seen = 1'b0;
            lane[c].main_on = 1'b0;
            lane[c].main_time = '0;
            lane[c].main_burst = 1'b1;
          end
          advance_spark(lane[c].main_burst, lane[c].main_on, lane[c].main_time,
                        lane[c].main_sparks, coil_cfg.primary_cycles);
        end
        // phased coil lags both edges; frozen while the second coil is off
        if (coil_cfg.second_coil_enable) begin
          if (lvl[c]) begin
            if (lane[c].phase_time >= coil_cfg.phasing_time) begin
              lane[c].phase_on = 1'b1;
              lane[c].phase_seen = 1'b1;
            end else begin
              lane[c].phase_on = 1'b0;
            end
          end else begin
            if (lane[c].phase_seen) begin
              lane[c].phase_seen = 1'b0;
              lane[c].phase_falling = 1'b1;
              lane[c].phase_time = '0;
            end
            if (lane[c].phase_falling) begin
              if (lane[c].phase_time >= coil_cfg.phasing_time) begin
                lane[c].phase_on = 1'b0;
                lane[c].phase_time = '0;
                lane[c].phase_falling = 1'b0;
                lane[c].phase_burst = 1'b1;
              end else begin
                lane[c].phase_on = 1'b1;
              end
            end
            if (!lane[c].phase_falling) begin
              advance_spark(lane[c].phase_burst, lane[c].phase_on, lane[c].phase_time,
                            lane[c].phase_sparks, coil_cfg.secondary_cycles);
            end
          end
        end
      end
      coils[2*c] = lane[c].main_on;
      coils[2*c+1] = lane[c].phase_on;
    end
    coil_q.push_back(coils);
  endtask

  // register write at the next edge; the caller lowers cfg_we after its last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_SECOND_COIL_ENABLE: coil_cfg.second_coil_enable = data[0];
      REG_PHASING_TIME: coil_cfg.phasing_time = data;
      REG_PRIMARY_CYCLES: coil_cfg.primary_cycles =
          (data[COUNT_W-1:0] > CYCLES_MAX) ? CYCLES_MAX : data[COUNT_W-1:0];
      REG_SECONDARY_CYCLES: coil_cfg.secondary_cycles =
          (data[COUNT_W-1:0] > CYCLES_MAX) ? CYCLES_MAX : data[COUNT_W-1:0];
      REG_BURST_INTERVAL: coil_cfg.burst_interval = data;
      REG_BURST_DWELL: coil_cfg.burst_dwell =
          (data[DWELL_W-1:0] > DWELL_MAX) ? DWELL_MAX : data[DWELL_W-1:0];
      default: ;
    endcase
  endtask

  // stop offering ticks and let every owed coil word come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (coil_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // offer one tick, after a random gap, and hold it until the transfer
  task automatic send_tick(input logic [NUM_IO-1:0] lvl);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    trig_level_a <= lvl[0];
    trig_level_b <= lvl[1];
    trig_level_c <= lvl[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(lvl);
  endtask

  // reset settings; unarmed channels stay low, then channel a arms
  task automatic test_reset_idle();
    send_tick(3'b000);
    send_tick(3'b000);
    send_tick(3'b001);
  endtask

  // main follow and burst on a, short pulse on b, c never armed
  task automatic test_follow_and_burst();
    wait_idle();
    write_reg(REG_SECOND_COIL_ENABLE, 16'h0001);
    write_reg(REG_PHASING_TIME, 16'd2);
    write_reg(REG_PRIMARY_CYCLES, 16'd3);
    write_reg(REG_SECONDARY_CYCLES, 16'd2);
    write_reg(REG_BURST_INTERVAL, 16'd1);
    write_reg(REG_BURST_DWELL, 16'd2);
    cfg_we <= 1'b0;
    send_tick(3'b011);
    send_tick(3'b001);
    send_tick(3'b001);
    repeat (7) send_tick(3'b000);
  endtask

  // b rises again while its burst is still running, c arms here
  task automatic test_retrigger();
    send_tick(3'b010);
    send_tick(3'b000);
    send_tick(3'b000);
    send_tick(3'b110);
    send_tick(3'b000);
    send_tick(3'b000);
  endtask

  // clamped and masked writes, dropped indexes, burst that ends at once
  task automatic test_clamps();
    wait_idle();
    write_reg(REG_PRIMARY_CYCLES, 16'hFFF8);
    write_reg(REG_SECONDARY_CYCLES, 16'h0009);
    write_reg(REG_BURST_DWELL, 16'hFFFF);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    write_reg(REG_SECOND_COIL_ENABLE, 16'hFFFF);
    cfg_we <= 1'b0;
    send_tick(3'b100);
    repeat (3) send_tick(3'b000);
    wait_idle();
    write_reg(REG_PRIMARY_CYCLES, 16'h0007);
    write_reg(REG_SECONDARY_CYCLES, 16'hFFFE);
    cfg_we <= 1'b0;
  endtask

  // phased coil keeps its level once the second coil is switched off
  task automatic test_frozen_phase();
    wait_idle();
    write_reg(REG_PHASING_TIME, 16'd1);
    write_reg(REG_BURST_DWELL, 16'd3);
    cfg_we <= 1'b0;
    repeat (3) send_tick(3'b001);
    wait_idle();
    write_reg(REG_SECOND_COIL_ENABLE, 16'hFFFE);
    cfg_we <= 1'b0;
    repeat (2) send_tick(3'b000);
  endtask

  // the receiver holds off for a long stretch while ticks keep coming
  task automatic test_backpressure();
    hold_requests++;
    repeat (40) send_tick(NUM_IO'($urandom));
  endtask

  // trigger waveforms of random pulse and gap lengths, settings redrawn per segment
  task automatic test_random_bursts(input int n_ticks);
    logic [NUM_IO-1:0] lvl;
    int burst_span;
    for (int i = 0; i < n_ticks; i++) begin
      if (i % 130 == 0) begin
        wait_idle();
        write_reg(REG_SECOND_COIL_ENABLE,
                  {15'($urandom), 1'($urandom_range(0, 3) != 0)});
        write_reg(REG_PHASING_TIME, 16'($urandom_range(0, 12)));
        write_reg(REG_PRIMARY_CYCLES, 16'($urandom));
        write_reg(REG_SECONDARY_CYCLES, 16'($urandom));
        write_reg(REG_BURST_INTERVAL, 16'($urandom_range(0, 8)));
        write_reg(REG_BURST_DWELL, {3'($urandom), 13'($urandom_range(0, 8))});
        cfg_we <= 1'b0;
      end
      burst_span = (int'(coil_cfg.primary_cycles) + 1) *
                   (int'(coil_cfg.burst_interval) + int'(coil_cfg.burst_dwell) + 2) +
                   2 * int'(coil_cfg.phasing_time) + 4;
      for (int c = 0; c < NUM_IO; c++) begin
        if (wave_left[c] == 0) begin
          wave_lvl[c] = ~wave_lvl[c];
          // some runs are glitches, the rest are full pulses and full gaps
          if ($urandom_range(0, 9) < 3) begin
            wave_left[c] = $urandom_range(1, 3);
          end else if (wave_lvl[c]) begin
            wave_left[c] = $urandom_range(1, 2 * int'(coil_cfg.phasing_time) + 4);
          end else begin
            wave_left[c] = $urandom_range(1, burst_span);
          end
        end
        wave_left[c]--;
      end
      lvl = wave_lvl;
      send_tick(lvl);
    end
  endtask

  // output side: random ready, or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // compare each output transfer with the oldest owed coil word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      coils_seen = {phased_coil_c, main_coil_c, phased_coil_b, main_coil_b,
                    phased_coil_a, main_coil_a};
      if (coil_q.size() == 0) begin
        $error("coil word %b with no tick waiting", coils_seen);
        mismatches++;
      end else begin
        coils_due = coil_q.pop_front();
        for (int i = 0; i < 2 * NUM_IO; i++) begin
          if (coils_seen[i] !== coils_due[i]) begin
            $error("%s: expected %0b, got %0b", coil_names[i], coils_due[i], coils_seen[i]);
            mismatches++;
          end
        end
      end
    end
  end

  // hang detection: too many cycles in a row without a transfer on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("multispark_ignition_pulse_generator regression: fail");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    trig_level_a <= 1'b0;
    trig_level_b <= 1'b0;
    trig_level_c <= 1'b0;
    coil_cfg = '{second_coil_enable: RST_SECOND_COIL_ENABLE,
                 phasing_time:       RST_PHASING_TIME,
                 primary_cycles:     RST_PRIMARY_CYCLES,
                 secondary_cycles:   RST_SECONDARY_CYCLES,
                 burst_interval:     RST_BURST_INTERVAL,
                 burst_dwell:        RST_BURST_DWELL};
    for (int c = 0; c < NUM_IO; c++) lane[c] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender idles often, receiver very often
    send_gap_pct = 30;
    recv_gap_pct = 74;
    test_reset_idle();
    test_follow_and_burst();
    test_retrigger();
    test_clamps();
    test_frozen_phase();
    test_backpressure();
    test_random_bursts(520);

    // roles swapped
    send_gap_pct = 74;
    recv_gap_pct = 30;
    test_random_bursts(520);

    // full rate on both sides
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_bursts(520);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && coil_q.size() == 0) begin
      $display("multispark_ignition_pulse_generator regression: pass");
    end else begin
      $display("multispark_ignition_pulse_generator regression: fail");
    end
    $finish;
  end

endmodule
